// ===== design/dait_pkg.sv =====
// dait_pkg: shared types, codes and constants for the divider and interval timer
// used by dait_core and divider_and_interval_timer; no dependencies
package dait_pkg;

   localparam int FRAME_PERIOD_DEF = 17564;

   localparam int ACTION_W   = 2;
   localparam int CYCLES_W   = 6;
   localparam int BYTE_W     = 8;
   localparam int FRAME_W    = 15;
   localparam int PRESCALE_W = 19;
   localparam int DIVPRE_W   = 7;
   localparam int CSR_IDX_W  = 2;

   localparam logic [DIVPRE_W-1:0] DIV_STEP = 7'd64;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ADVANCE = 2'd0,
      ACT_WRITE   = 2'd1,
      ACT_CLEAR   = 2'd2
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TIMER_ENABLE = 2'd0,
      CSR_CLOCK_SELECT = 2'd1,
      CSR_RELOAD_VALUE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic              timer_enable;
      logic [1:0]        clock_select;
      logic [BYTE_W-1:0] reload_value;
   } cfg_type;

   typedef struct packed {
      logic              frame_irq;
      logic              timer_irq;
      logic [BYTE_W-1:0] divider_value;
      logic [BYTE_W-1:0] counter_value;
   } rsp_type;

   function automatic logic [PRESCALE_W-1:0] timer_threshold(input logic [1:0] sel);
      logic [PRESCALE_W-1:0] t;
      case (sel)
         2'd0:    t = 19'd4096;
         2'd1:    t = 19'd262144;
         2'd2:    t = 19'd65536;
         default: t = 19'd16384;
      endcase
      return t;
   endfunction

endpackage

// ===== design/divider_and_interval_timer.sv =====
// Divider and interval timer. Each item advances time, writes the interval counter,
// clears the divider or, with the unused action code, changes nothing, and gives exactly
// one result item. An item is taken every cycle while the result side keeps up; once
// accepted it waits in the input register while the step logic settles, and moves into
// the result register, which drives the outputs, once that register is free or being
// read. The accumulator adds and compares of one step settle combinationally. The input
// stalls only while both registers hold an item and the result side is stalling.
// Reset clears all timer state and configuration; no clearing pass is needed.
// depends on dait_pkg and dait_core
module divider_and_interval_timer #(
   parameter int FRAME_PERIOD = dait_pkg::FRAME_PERIOD_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [dait_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dait_pkg::BYTE_W-1:0]       csr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [dait_pkg::ACTION_W-1:0]     req_action,
   input  logic [dait_pkg::CYCLES_W-1:0]     req_cycles,
   input  logic [dait_pkg::BYTE_W-1:0]       req_write_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_frame_irq,
   output logic                              rsp_timer_irq,
   output logic [dait_pkg::BYTE_W-1:0]       rsp_divider_value,
   output logic [dait_pkg::BYTE_W-1:0]       rsp_counter_value
);
   import dait_pkg::*;

   cfg_type               cfg_ff;
   logic                  in_valid_ff;
   logic [ACTION_W-1:0]   in_action_ff;
   logic [CYCLES_W-1:0]   in_cycles_ff;
   logic [BYTE_W-1:0]     in_write_value_ff;
   logic                  out_valid_ff;
   rsp_type               out_ff;
   rsp_type               step_result;
   logic                  advance;

   // item moves from input register into result register
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_TIMER_ENABLE: cfg_ff.timer_enable <= csr_data[0];
            CSR_CLOCK_SELECT: cfg_ff.clock_select <= csr_data[1:0];
            CSR_RELOAD_VALUE: cfg_ff.reload_value <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_action_ff      <= req_action;
         in_cycles_ff      <= req_cycles;
         in_write_value_ff <= req_write_value;
      end
   end

   dait_core #(
      .FRAME_PERIOD (FRAME_PERIOD)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .action      (in_action_ff),
      .cycles      (in_cycles_ff),
      .write_value (in_write_value_ff),
      .cfg         (cfg_ff),
      .result      (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_frame_irq     = out_ff.frame_irq;
   assign rsp_timer_irq     = out_ff.timer_irq;
   assign rsp_divider_value = out_ff.divider_value;
   assign rsp_counter_value = out_ff.counter_value;

endmodule

// ===== design/dait_core.sv =====
// dait_core: timer state (frame, prescalers, divider, interval counter) and step logic
// depends on dait_pkg
module dait_core #(
   parameter int FRAME_PERIOD = dait_pkg::FRAME_PERIOD_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step,
   input  logic [dait_pkg::ACTION_W-1:0]        action,
   input  logic [dait_pkg::CYCLES_W-1:0]        cycles,
   input  logic [dait_pkg::BYTE_W-1:0]          write_value,
   input  dait_pkg::cfg_type                    cfg,
   output dait_pkg::rsp_type                    result
);
   import dait_pkg::*;

   localparam logic [FRAME_W-1:0] FRAME_LIMIT = FRAME_W'(FRAME_PERIOD);

   logic [FRAME_W-1:0]    frame_accum_ff,      frame_accum_in;
   logic [PRESCALE_W-1:0] timer_prescale_ff,   timer_prescale_in;
   logic [DIVPRE_W-1:0]   divider_prescale_ff, divider_prescale_in;
   logic [BYTE_W-1:0]     divider_reg_ff,      divider_reg_in;
   logic [BYTE_W-1:0]     interval_counter_ff, interval_counter_in;

   logic [FRAME_W-1:0]    frame_sum;
   logic [PRESCALE_W-1:0] timer_sum;
   logic [DIVPRE_W-1:0]   div_sum;
   logic [BYTE_W-1:0]     counter_inc;
   logic                  frame_irq;
   logic                  timer_irq;

   always_comb begin
      frame_sum   = frame_accum_ff + FRAME_W'(cycles);
      timer_sum   = timer_prescale_ff + PRESCALE_W'(cycles);
      div_sum     = divider_prescale_ff + DIVPRE_W'(cycles);
      counter_inc = interval_counter_ff + 8'd1;

      frame_accum_in      = frame_accum_ff;
      timer_prescale_in   = timer_prescale_ff;
      divider_prescale_in = divider_prescale_ff;
      divider_reg_in      = divider_reg_ff;
      interval_counter_in = interval_counter_ff;
      frame_irq           = 1'b0;
      timer_irq           = 1'b0;

      case (action)
         ACT_ADVANCE: begin
            if (frame_sum >= FRAME_LIMIT) begin
               frame_irq      = 1'b1;
               frame_accum_in = '0;
            end else begin
               frame_accum_in = frame_sum;
            end
            if (cfg.timer_enable) begin
               if (timer_sum >= timer_threshold(cfg.clock_select)) begin
                  timer_prescale_in = '0;
                  if (counter_inc == '0) begin
                     interval_counter_in = cfg.reload_value;
                     timer_irq           = 1'b1;
                  end else begin
                     interval_counter_in = counter_inc;
                  end
               end else begin
                  timer_prescale_in = timer_sum;
               end
            end
            if (div_sum >= DIV_STEP) begin
               divider_prescale_in = '0;
               divider_reg_in      = divider_reg_ff + 8'd1;
            end else begin
               divider_prescale_in = div_sum;
            end
         end
         ACT_WRITE: begin
            interval_counter_in = write_value;
         end
         ACT_CLEAR: begin
            divider_reg_in      = '0;
            divider_prescale_in = '0;
         end
         default: begin
         end
      endcase

      result.frame_irq     = frame_irq;
      result.timer_irq     = timer_irq;
      result.divider_value = divider_reg_in;
      result.counter_value = interval_counter_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_accum_ff      <= '0;
         timer_prescale_ff   <= '0;
         divider_prescale_ff <= '0;
         divider_reg_ff      <= '0;
         interval_counter_ff <= '0;
      end else if (step) begin
         frame_accum_ff      <= frame_accum_in;
         timer_prescale_ff   <= timer_prescale_in;
         divider_prescale_ff <= divider_prescale_in;
         divider_reg_ff      <= divider_reg_in;
         interval_counter_ff <= interval_counter_in;
      end
   end

endmodule

// ===== verif/tb.sv =====
// tb: self-checking testbench for divider_and_interval_timer, with an in-bench timer model
// fed by a directed item list and random item sequences under random stalls on both sides
// depends on dait_pkg and divider_and_interval_timer
module tb;
   import dait_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD = 300;
   localparam int N_DIRECTED = 19;

   typedef struct packed {
      logic [ACTION_W-1:0] act;
      logic [CYCLES_W-1:0] cyc;
      logic [BYTE_W-1:0]   wval;
      logic                typed;
      rsp_type             rsp;
   } stim_row_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [BYTE_W-1:0]    csr_data;
   logic                 req_valid;
   logic                 req_stall;
   logic [ACTION_W-1:0]  req_action;
   logic [CYCLES_W-1:0]  req_cycles;
   logic [BYTE_W-1:0]    req_write_value;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_frame_irq;
   logic                 rsp_timer_irq;
   logic [BYTE_W-1:0]    rsp_divider_value;
   logic [BYTE_W-1:0]    rsp_counter_value;

   divider_and_interval_timer dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_cycles        (req_cycles),
      .req_write_value   (req_write_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_irq     (rsp_frame_irq),
      .rsp_timer_irq     (rsp_timer_irq),
      .rsp_divider_value (rsp_divider_value),
      .rsp_counter_value (rsp_counter_value)
   );

   // timer model state and its copy of the registers
   logic [FRAME_W-1:0]    frame_acc;
   logic [PRESCALE_W-1:0] tick_pre;
   logic [DIVPRE_W-1:0]   div_pre;
   logic [BYTE_W-1:0]     div_cnt;
   logic [BYTE_W-1:0]     ivl_cnt;
   logic                  cfg_en;
   logic [1:0]            cfg_sel;
   logic [BYTE_W-1:0]     cfg_reload;

   rsp_type      expected_rsp[$];
   stim_row_type directed_rows [0:N_DIRECTED-1];
   int unsigned  errors = 0;
   int unsigned  quiet_cycles = 0;
   int           hold_left = 0;
   bit           long_hold = 1'b0;
   bit           allow_gaps = 1'b1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function rsp_type timer_step(input logic [ACTION_W-1:0] act, input logic [CYCLES_W-1:0] cyc,
                                input logic [BYTE_W-1:0] wval);
      rsp_type r;
      logic [PRESCALE_W-1:0] limit;
      r = '0;
      case (act)
         ACT_ADVANCE: begin
            frame_acc = frame_acc + FRAME_W'(cyc);
            if (frame_acc >= FRAME_W'(FRAME_PERIOD_DEF)) begin
               r.frame_irq = 1'b1;
               frame_acc = '0;
            end
            if (cfg_en) begin
               case (cfg_sel)
                  2'd0:    limit = 19'd4096;
                  2'd1:    limit = 19'd262144;
                  2'd2:    limit = 19'd65536;
                  default: limit = 19'd16384;
               endcase
               tick_pre = tick_pre + PRESCALE_W'(cyc);
               if (tick_pre >= limit) begin
                  tick_pre = '0;
                  if (ivl_cnt == 8'hFF) begin
                     ivl_cnt = cfg_reload;
                     r.timer_irq = 1'b1;
                  end else begin
                     ivl_cnt = ivl_cnt + 8'd1;
                  end
               end
            end
            div_pre = div_pre + DIVPRE_W'(cyc);
            if (div_pre >= 7'd64) begin
               div_pre = '0;
               div_cnt = div_cnt + 8'd1;
            end
         end
         ACT_WRITE: ivl_cnt = wval;
         ACT_CLEAR: begin
            div_cnt = '0;
            div_pre = '0;
         end
         default: ;
      endcase
      r.divider_value = div_cnt;
      r.counter_value = ivl_cnt;
      return r;
   endfunction

   task flag_error(input string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
   endtask

   task offer_item(input logic [ACTION_W-1:0] act, input logic [CYCLES_W-1:0] cyc,
                   input logic [BYTE_W-1:0] wval, input bit typed, input rsp_type typed_rsp);
      rsp_type r;
      int gap;
      if (allow_gaps && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 17);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_action      <= act;
      req_cycles      <= cyc;
      req_write_value <= wval;
      do @(posedge clock); while (req_stall);
      r = timer_step(act, cyc, wval);
      expected_rsp.push_back(typed ? typed_rsp : r);
   endtask

   task wait_drained;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task write_reg(input csr_index_type idx, input logic [BYTE_W-1:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      case (idx)
         CSR_TIMER_ENABLE: cfg_en = val[0];
         CSR_CLOCK_SELECT: cfg_sel = val[1:0];
         default:          cfg_reload = val;
      endcase
   endtask

   task configure(input logic en, input logic [1:0] sel, input logic [BYTE_W-1:0] reload);
      wait_drained();
      write_reg(CSR_TIMER_ENABLE, {7'd0, en});
      write_reg(CSR_CLOCK_SELECT, {6'd0, sel});
      write_reg(CSR_RELOAD_VALUE, reload);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // counter write then mostly long advances, or long advances only; counter can roll over
   task run_phase(input int n_items, input bit only_advance);
      int sent;
      int seq_left;
      int r;
      logic [BYTE_W-1:0] wv;
      sent = 0;
      seq_left = 0;
      while (sent < n_items) begin
         if (only_advance) begin
            offer_item(ACT_ADVANCE, CYCLES_W'($urandom_range(32, 63)), BYTE_W'($urandom), 0, '0);
         end else if (seq_left == 0) begin
            r = $urandom_range(0, 3);
            wv = (r == 0) ? 8'hFF : (r == 1) ? 8'hFE : (r == 2) ? 8'hFC : BYTE_W'($urandom);
            offer_item(ACT_WRITE, CYCLES_W'($urandom), wv, 0, '0);
            seq_left = $urandom_range(20, 140);
         end else begin
            r = $urandom_range(0, 99);
            seq_left--;
            if (r < 3)
               offer_item(ACT_CLEAR, CYCLES_W'($urandom), BYTE_W'($urandom), 0, '0);
            else if (r < 6)
               offer_item(ACT_SPARE, CYCLES_W'($urandom), BYTE_W'($urandom), 0, '0);
            else if (r < 8)
               offer_item(ACT_WRITE, CYCLES_W'($urandom), BYTE_W'($urandom), 0, '0);
            else if ($urandom_range(0, 3) == 0)
               offer_item(ACT_ADVANCE, CYCLES_W'($urandom), BYTE_W'($urandom), 0, '0);
            else
               offer_item(ACT_ADVANCE, CYCLES_W'($urandom_range(40, 63)), BYTE_W'($urandom),
                          0, '0);
         end
         sent++;
      end
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (long_hold) begin
         long_hold = 1'b0;
         hold_left = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else if (allow_gaps && !reset && $urandom_range(0, 9) == 0) begin
         hold_left = $urandom_range(0, 16);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_frame_irq, rsp_timer_irq, rsp_divider_value, rsp_counter_value};
         if (expected_rsp.size() == 0) begin
            flag_error($sformatf("unexpected item: frame=%0d timer=%0d div=%0d cnt=%0d",
                                 got.frame_irq, got.timer_irq, got.divider_value,
                                 got.counter_value));
         end else begin
            want = expected_rsp.pop_front();
            if (got !== want)
               flag_error($sformatf({"mismatch: expected frame=%0d timer=%0d div=%0d cnt=%0d,",
                                     " got frame=%0d timer=%0d div=%0d cnt=%0d"},
                                    want.frame_irq, want.timer_irq, want.divider_value,
                                    want.counter_value, got.frame_irq, got.timer_irq,
                                    got.divider_value, got.counter_value));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_valid = 1'b0;
      req_action = '0;
      req_cycles = '0;
      req_write_value = '0;
      rsp_stall = 1'b0;
      frame_acc = '0;
      tick_pre = '0;
      div_pre = '0;
      div_cnt = '0;
      ivl_cnt = '0;
      cfg_en = 1'b0;
      cfg_sel = '0;
      cfg_reload = '0;

      // timer disabled after reset; typed rows can be read off directly
      directed_rows = '{
         '{ACT_ADVANCE, 6'd0,  8'd0,   1'b1, '{1'b0, 1'b0, 8'd0, 8'd0}},
         '{ACT_SPARE,   6'd63, 8'd255, 1'b1, '{1'b0, 1'b0, 8'd0, 8'd0}},
         '{ACT_WRITE,   6'd0,  8'd255, 1'b1, '{1'b0, 1'b0, 8'd0, 8'd255}},
         '{ACT_WRITE,   6'd63, 8'd0,   1'b1, '{1'b0, 1'b0, 8'd0, 8'd0}},
         '{ACT_ADVANCE, 6'd63, 8'd255, 1'b1, '{1'b0, 1'b0, 8'd0, 8'd0}},
         '{ACT_ADVANCE, 6'd1,  8'd0,   1'b1, '{1'b0, 1'b0, 8'd1, 8'd0}},
         '{ACT_ADVANCE, 6'd63, 8'd0,   1'b1, '{1'b0, 1'b0, 8'd1, 8'd0}},
         '{ACT_ADVANCE, 6'd63, 8'd0,   1'b1, '{1'b0, 1'b0, 8'd2, 8'd0}},
         '{ACT_CLEAR,   6'd63, 8'd255, 1'b1, '{1'b0, 1'b0, 8'd0, 8'd0}},
         '{ACT_WRITE,   6'd0,  8'hAA,  1'b1, '{1'b0, 1'b0, 8'd0, 8'hAA}},
         '{ACT_WRITE,   6'd0,  8'h55,  1'b1, '{1'b0, 1'b0, 8'd0, 8'h55}},
         '{ACT_ADVANCE, 6'h2A, 8'h55,  1'b0, '0},
         '{ACT_ADVANCE, 6'h15, 8'hAA,  1'b0, '0},
         '{ACT_SPARE,   6'd0,  8'd0,   1'b0, '0},
         '{ACT_ADVANCE, 6'd32, 8'd0,   1'b0, '0},
         '{ACT_CLEAR,   6'd0,  8'd0,   1'b0, '0},
         '{ACT_ADVANCE, 6'd0,  8'd0,   1'b0, '0},
         '{ACT_WRITE,   6'd0,  8'hFF,  1'b0, '0},
         '{ACT_ADVANCE, 6'd63, 8'd0,   1'b0, '0}
      };

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++)
         offer_item(directed_rows[i].act, directed_rows[i].cyc, directed_rows[i].wval,
                    directed_rows[i].typed, directed_rows[i].rsp);

      configure(1'b1, 2'd0, 8'h00);
      run_phase(260, 1'b0);
      // build up the prescaler on the slowest tick, with the result side held off for a while
      configure(1'b1, 2'd1, BYTE_W'($urandom));
      long_hold = 1'b1;
      run_phase(200, 1'b1);
      // switch to a threshold the prescaler is already past
      configure(1'b1, 2'd0, 8'hFF);
      run_phase(150, 1'b0);
      configure(1'b0, 2'd2, BYTE_W'($urandom));
      run_phase(60, 1'b0);
      configure(1'b1, 2'd3, 8'h80);
      run_phase(160, 1'b0);
      allow_gaps = 1'b0;
      configure(1'b1, 2'd0, BYTE_W'($urandom));
      run_phase(120, 1'b0);

      wait_drained();
      repeat (8) @(posedge clock);
      if (expected_rsp.size() != 0)
         flag_error($sformatf("%0d items never came out", expected_rsp.size()));
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
